// ===== rtl/jeo_pkg.sv =====
// Shared types, codes and the control store of the Josephus order sequencer.
package jeo_pkg;

   localparam int DATA_W = 11;
   localparam int PC_W   = 4;

   // register indexes on the csr port
   localparam logic CSR_PEOPLE_COUNT = 1'b0;
   localparam logic CSR_STEP_K       = 1'b1;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_BUILD_INIT,
      OP_BUILD,
      OP_LOAD_K,
      OP_WALK,
      OP_UNLINK,
      OP_EMIT_EMPTY
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOREQ,
      C_NORESTART,
      C_BUILD_MORE,
      C_EMPTY,
      C_WALK_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uinstr_type;

   typedef struct packed {
      logic req_valid;
      logic restart;
      logic build_more;
      logic ring_empty;
      logic walk_more;
      logic out_busy;
   } status_type;

   // program labels
   localparam pc_type PC_WAIT   = 4'd0;
   localparam pc_type PC_BUILD  = 4'd3;
   localparam pc_type PC_CHECK  = 4'd4;
   localparam pc_type PC_WALK   = 4'd5;
   localparam pc_type PC_FETCH  = 4'd6;
   localparam pc_type PC_EMPTY  = 4'd8;

   // taken jump goes to target, otherwise pc + 1
   function automatic uinstr_type ucode_rom(input pc_type pc);
      uinstr_type w;
      case (pc)
         4'd0:    w = '{op: OP_ACCEPT,     cond: C_NOREQ,      target: PC_WAIT};
         4'd1:    w = '{op: OP_NOP,        cond: C_NORESTART,  target: PC_CHECK};
         4'd2:    w = '{op: OP_BUILD_INIT, cond: C_NEVER,      target: PC_WAIT};
         4'd3:    w = '{op: OP_BUILD,      cond: C_BUILD_MORE, target: PC_BUILD};
         4'd4:    w = '{op: OP_LOAD_K,     cond: C_EMPTY,      target: PC_EMPTY};
         4'd5:    w = '{op: OP_WALK,       cond: C_WALK_MORE,  target: PC_WALK};
         4'd6:    w = '{op: OP_NOP,        cond: C_OUT_BUSY,   target: PC_FETCH};
         4'd7:    w = '{op: OP_UNLINK,     cond: C_ALWAYS,     target: PC_WAIT};
         4'd8:    w = '{op: OP_NOP,        cond: C_OUT_BUSY,   target: PC_EMPTY};
         4'd9:    w = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,     target: PC_WAIT};
         default: w = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/jeo_useq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
module jeo_useq (
   input  logic                clock,
   input  logic                reset,
   input  jeo_pkg::status_type status,
   output jeo_pkg::op_type     op
);
   import jeo_pkg::*;

   pc_type     pc_ff;
   pc_type     pc_in;
   uinstr_type uinstr;
   logic       taken;

   always_comb begin
      uinstr = ucode_rom(pc_ff);
      case (uinstr.cond)
         C_NEVER:      taken = 1'b0;
         C_ALWAYS:     taken = 1'b1;
         C_NOREQ:      taken = !status.req_valid;
         C_NORESTART:  taken = !status.restart;
         C_BUILD_MORE: taken = status.build_more;
         C_EMPTY:      taken = status.ring_empty;
         C_WALK_MORE:  taken = status.walk_more;
         C_OUT_BUSY:   taken = status.out_busy;
         default:      taken = 1'b1;
      endcase
      pc_in = taken ? uinstr.target : pc_type'(pc_ff + 1'b1);
      op    = uinstr.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/jeo_datapath.sv =====
// Ring datapath: link memories, position and count registers, result register.
module jeo_datapath #(
   parameter int MAX_PEOPLE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  jeo_pkg::op_type             op,
   output jeo_pkg::status_type         status,
   input  logic                        req_tvalid,
   input  logic                        req_restart,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [jeo_pkg::DATA_W-1:0]  csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [jeo_pkg::DATA_W-1:0]  rsp_person,
   output logic                        rsp_last,
   output logic                        rsp_empty
);
   import jeo_pkg::*;

   localparam int SLOT_W = $clog2(MAX_PEOPLE);
   localparam int CNT_W  = $clog2(MAX_PEOPLE + 1);

   logic [DATA_W-1:0] people_ff, step_k_ff;
   logic              restart_ff, restart_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] kcnt_ff, kcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] person_ff, person_in;
   logic              last_ff, last_in;
   logic              empty_ff, empty_in;

   logic [SLOT_W-1:0] next_mem [MAX_PEOPLE];
   logic [SLOT_W-1:0] prev_mem [MAX_PEOPLE];
   logic [SLOT_W-1:0] next_rd_ff, prev_rd_ff;

   logic              next_we, prev_we;
   logic [SLOT_W-1:0] next_waddr, prev_waddr, next_wdata, prev_wdata;
   logic [SLOT_W-1:0] next_raddr;
   logic [SLOT_W-1:0] nx, pv;
   logic [CNT_W-1:0]  count_sat;
   logic [CNT_W-1:0]  idx_plus;
   logic              out_busy;

   // out-of-range link values fall back to slot 0
   assign nx = (32'(next_rd_ff) < MAX_PEOPLE) ? next_rd_ff : '0;
   assign pv = (32'(prev_rd_ff) < MAX_PEOPLE) ? prev_rd_ff : '0;

   assign count_sat = (32'(people_ff) > MAX_PEOPLE) ? CNT_W'(MAX_PEOPLE) : CNT_W'(people_ff);
   assign idx_plus  = CNT_W'(idx_ff + 1'b1);
   assign out_busy  = rsp_valid_ff && !rsp_tready;

   assign status.req_valid  = req_tvalid;
   assign status.restart    = restart_ff;
   assign status.build_more = idx_plus < remaining_ff;
   assign status.ring_empty = remaining_ff == '0;
   assign status.walk_more  = kcnt_ff > DATA_W'(1);
   assign status.out_busy   = out_busy;

   always_comb begin
      restart_in   = restart_ff;
      pos_in       = pos_ff;
      remaining_in = remaining_ff;
      idx_in       = idx_ff;
      kcnt_in      = kcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      person_in    = person_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      next_we      = 1'b0;
      prev_we      = 1'b0;
      next_waddr   = idx_ff[SLOT_W-1:0];
      prev_waddr   = idx_ff[SLOT_W-1:0];
      next_wdata   = '0;
      prev_wdata   = '0;
      next_raddr   = pos_ff;
      case (op)
         OP_ACCEPT: begin
            if (req_tvalid) begin
               restart_in = req_restart;
            end
         end
         OP_BUILD_INIT: begin
            idx_in       = '0;
            pos_in       = '0;
            remaining_in = count_sat;
         end
         OP_BUILD: begin
            // remaining holds the ring size while building
            next_we    = idx_ff < remaining_ff;
            prev_we    = idx_ff < remaining_ff;
            next_wdata = (idx_plus < remaining_ff) ? idx_plus[SLOT_W-1:0] : '0;
            prev_wdata = (idx_ff == '0) ? SLOT_W'(remaining_ff - 1'b1)
                                        : SLOT_W'(idx_ff - 1'b1);
            idx_in     = idx_plus;
         end
         OP_LOAD_K: begin
            kcnt_in = (step_k_ff == '0) ? '0 : DATA_W'(step_k_ff - 1'b1);
         end
         OP_WALK: begin
            // follow one link per cycle straight off the registered read
            if (kcnt_ff != '0) begin
               pos_in     = nx;
               next_raddr = nx;
               kcnt_in    = DATA_W'(kcnt_ff - 1'b1);
            end
         end
         OP_UNLINK: begin
            prev_we      = 1'b1;
            prev_waddr   = nx;
            prev_wdata   = pv;
            next_we      = 1'b1;
            next_waddr   = pv;
            next_wdata   = nx;
            pos_in       = nx;
            remaining_in = CNT_W'(remaining_ff - 1'b1);
            rsp_valid_in = 1'b1;
            person_in    = DATA_W'({1'b0, pos_ff} + 1'b1);
            last_in      = remaining_ff == CNT_W'(1);
            empty_in     = 1'b0;
         end
         OP_EMIT_EMPTY: begin
            rsp_valid_in = 1'b1;
            person_in    = '0;
            last_in      = 1'b0;
            empty_in     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         people_ff    <= DATA_W'(1);
         step_k_ff    <= DATA_W'(1);
         restart_ff   <= 1'b0;
         pos_ff       <= '0;
         remaining_ff <= '0;
         idx_ff       <= '0;
         kcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PEOPLE_COUNT: people_ff <= csr_wdata;
               CSR_STEP_K:       step_k_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         restart_ff   <= restart_in;
         pos_ff       <= pos_in;
         remaining_ff <= remaining_in;
         idx_ff       <= idx_in;
         kcnt_ff      <= kcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      person_ff <= person_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_person = person_ff;
   assign rsp_last   = last_ff;
   assign rsp_empty  = empty_ff;

endmodule

// ===== rtl/josephus_elimination_order_top.sv =====
// Top level of the Josephus elimination order generator.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata[0] restart
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata[10:0] person, tlast, tuser empty
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// A request with restart first builds a ring of min(people_count, MAX_PEOPLE)
// people; a count of zero still passes through the build init and one build step.
// The walk then follows one next link per cycle, step_k - 1 links (none for a step
// of zero), with accept, dispatch, step load, fetch and unlink with result load;
// the single link memory read port per cycle sets that rate. An empty ring is
// answered after accept, dispatch and step load, with the empty result load.
// Reset is synchronous; the link memories are not cleared and need no sweep.
// A result stalled on rsp_tready holds the sequencer before its next result
// load, while a further request is still taken.
module josephus_elimination_order_top #(
   parameter int MAX_PEOPLE = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] restart
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [10:0] person
   output logic                       rsp_tlast,
   output logic                       rsp_tuser,   // [0] empty_res
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [jeo_pkg::DATA_W-1:0] csr_wdata
);
   import jeo_pkg::*;

   op_type            op;
   status_type        status;
   logic [DATA_W-1:0] person;

   jeo_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   jeo_datapath #(
      .MAX_PEOPLE (MAX_PEOPLE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_person  (person),
      .rsp_last    (rsp_tlast),
      .rsp_empty   (rsp_tuser)
   );

   assign req_tready = op == OP_ACCEPT;
   assign rsp_tdata  = {5'b0, person};

endmodule

// ===== rtl/jeo_checker.sv =====
// Port-level checks on the Josephus order generator, bound to its top level.
module jeo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // an empty-ring answer carries no person and no last mark
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[10:0] == 11'd0 && !rsp_tlast)
      else $error("empty result with person or last set");

   // a real elimination never reports person 0
   a_person_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[10:0] != 11'd0)
      else $error("elimination reported person 0");

   // the sequencer is busy the cycle after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind josephus_elimination_order_top jeo_checker u_jeo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/tb_josephus_elimination_order_top.sv =====
// Testbench for the Josephus elimination order generator: directed table, then random rings.
`timescale 1ns / 1ps

module tb_josephus_elimination_order_top;
   import jeo_pkg::*;

   localparam int RING_MAX     = 1024;
   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 550;

   typedef struct packed {
      logic [10:0] person;
      logic        last;
      logic        empty;
   } elim_type;

   typedef enum logic [1:0] {
      ROW_REQUEST,
      ROW_SET_COUNT,
      ROW_SET_STEP
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [10:0]  value;   // restart in bit 0 for a request row
      logic         pinned;
      elim_type     pin;
   } plan_row_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;    // [0] restart
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;          // [10:0] person
   logic              rsp_tlast;
   logic              rsp_tuser;          // [0] empty_res
   logic              csr_we     = 1'b0;
   logic              csr_index  = 1'b0;
   logic [DATA_W-1:0] csr_wdata  = '0;

   josephus_elimination_order_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ring model
   logic [10:0] count_cfg = 11'd1;
   logic [10:0] step_cfg  = 11'd1;
   logic [9:0]  next_slot [RING_MAX];
   logic [9:0]  prev_slot [RING_MAX];
   logic [9:0]  cur_slot  = '0;
   logic [10:0] ring_left = '0;

   elim_type     results_due [$];
   plan_row_type plan [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int rebuilds      = 0;
   int empties_seen  = 0;
   int stall_cycles  = 0;
   int max_ring      = 0;

   function automatic elim_type eliminate_next(input logic restart);
      elim_type    r;
      int          n;
      logic [9:0]  pos;
      logic [9:0]  nx;
      logic [9:0]  pv;
      if (restart) begin
         n = (count_cfg > 11'(RING_MAX)) ? RING_MAX : int'(count_cfg);
         for (int i = 0; i < n; i++) begin
            next_slot[i] = (i + 1 < n) ? 10'(i + 1) : 10'd0;
            prev_slot[i] = (i == 0) ? 10'(n - 1) : 10'(i - 1);
         end
         cur_slot  = '0;
         ring_left = 11'(n);
         if (n > max_ring) max_ring = n;
      end
      if (ring_left == 0) begin
         r = '{person: 11'd0, last: 1'b0, empty: 1'b1};
         return r;
      end
      pos = cur_slot;
      // step of zero walks like a step of one
      for (int j = 1; j < int'(step_cfg); j++) pos = next_slot[pos];
      r = '{person: 11'(pos) + 11'd1, last: (ring_left == 11'd1), empty: 1'b0};
      nx = next_slot[pos];
      pv = prev_slot[pos];
      prev_slot[nx] = pv;
      next_slot[pv] = nx;
      cur_slot  = nx;
      ring_left = ring_left - 11'd1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // every task below begins on a falling edge
   task automatic send_request(input logic restart, input logic pinned, input elim_type pin);
      elim_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      predicted = eliminate_next(restart);
      results_due.push_back(pinned ? pin : predicted);
      requests_sent++;
      if (restart) rebuilds++;
   endtask

   task automatic wait_drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [10:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_PEOPLE_COUNT) count_cfg = val;
      else step_cfg = val;
   endtask

   function automatic plan_row_type req_row(input logic restart);
      return '{kind: ROW_REQUEST, value: {10'd0, restart}, pinned: 1'b0, pin: '0};
   endfunction

   function automatic plan_row_type pinned_row(input logic restart, input logic [10:0] person,
                                               input logic last, input logic empty);
      return '{kind: ROW_REQUEST, value: {10'd0, restart}, pinned: 1'b1,
               pin: '{person: person, last: last, empty: empty}};
   endfunction

   function automatic plan_row_type cfg_row(input row_kind_type kind,
                                            input logic [10:0] value);
      return '{kind: kind, value: value, pinned: 1'b0, pin: '0};
   endfunction

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      elim_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) empties_seen++;
         if (results_due.size() == 0) begin
            $display("[%0t] result with no request outstanding: person %0d",
                     $time, rsp_tdata[10:0]);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata[10:0] !== want.person)
               report_mismatch("person", rsp_tdata[10:0], want.person);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
            if (rsp_tuser !== want.empty) report_mismatch("empty", rsp_tuser, want.empty);
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d results outstanding", results_due.size());
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int          directed_items;
      int          random_sent;
      int          run_len;
      logic [10:0] count_pick;
      logic [10:0] step_pick;
      logic        restart;
      logic        noisy;

      // no ring yet, then the one-person ring from reset values
      plan.push_back(pinned_row(1'b0, 11'd0, 1'b0, 1'b1));
      plan.push_back(pinned_row(1'b1, 11'd1, 1'b1, 1'b0));
      plan.push_back(pinned_row(1'b0, 11'd0, 1'b0, 1'b1));
      // zero people: restart still reports empty
      plan.push_back(cfg_row(ROW_SET_COUNT, 11'd0));
      plan.push_back(pinned_row(1'b1, 11'd0, 1'b0, 1'b1));
      // classic 7 / 3 ring run to the end and one past
      plan.push_back(cfg_row(ROW_SET_COUNT, 11'd7));
      plan.push_back(cfg_row(ROW_SET_STEP, 11'd3));
      plan.push_back(req_row(1'b1));
      repeat (6) plan.push_back(req_row(1'b0));
      plan.push_back(pinned_row(1'b0, 11'd0, 1'b0, 1'b1));
      // zero step acts as one
      plan.push_back(cfg_row(ROW_SET_STEP, 11'd0));
      plan.push_back(pinned_row(1'b1, 11'd1, 1'b0, 1'b0));
      plan.push_back(req_row(1'b0));
      // all ones: count saturates, step wraps the full ring
      plan.push_back(cfg_row(ROW_SET_COUNT, 11'h7FF));
      plan.push_back(cfg_row(ROW_SET_STEP, 11'h7FF));
      plan.push_back(req_row(1'b1));
      plan.push_back(req_row(1'b0));
      plan.push_back(cfg_row(ROW_SET_COUNT, 11'd1024));
      plan.push_back(cfg_row(ROW_SET_STEP, 11'd1024));
      plan.push_back(pinned_row(1'b1, 11'd1024, 1'b0, 1'b0));
      plan.push_back(req_row(1'b0));
      // step far past a small ring, restart in mid-run
      plan.push_back(cfg_row(ROW_SET_COUNT, 11'd3));
      plan.push_back(cfg_row(ROW_SET_STEP, 11'd10));
      plan.push_back(req_row(1'b1));
      plan.push_back(req_row(1'b0));
      plan.push_back(req_row(1'b1));
      repeat (3) plan.push_back(req_row(1'b0));
      plan.push_back(pinned_row(1'b0, 11'd0, 1'b0, 1'b1));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 72;
      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_SET_COUNT: begin
               wait_drain();
               write_reg(CSR_PEOPLE_COUNT, plan[i].value);
            end
            ROW_SET_STEP: begin
               wait_drain();
               write_reg(CSR_STEP_K, plan[i].value);
            end
            default: send_request(plan[i].value[0], plan[i].pinned, plan[i].pin);
         endcase
      end
      directed_items = requests_sent;

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 72;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_drain();
         // mostly small rings run to completion; now and then a big one cut short
         if ($urandom_range(19) == 0) begin
            count_pick = 11'($urandom_range(2047, 900));
            step_pick  = 11'($urandom_range(2047, 0));
            run_len    = $urandom_range(12, 4);
         end else begin
            count_pick = 11'($urandom_range(24, 0));
            step_pick  = 11'($urandom_range(40, 0));
            run_len    = int'(count_pick) + $urandom_range(2, 0);
            if (run_len == 0) run_len = 1;
         end
         write_reg(CSR_PEOPLE_COUNT, count_pick);
         write_reg(CSR_STEP_K, step_pick);
         noisy = ($urandom_range(9) == 0);
         for (int i = 0; i < run_len; i++) begin
            if (i == 0) restart = 1'b1;
            else if (noisy) restart = 1'($urandom_range(1));
            else restart = ($urandom_range(29) == 0);
            send_request(restart, 1'b0, '0);
            random_sent++;
            if ($urandom_range(49) == 0) wait_drain();
         end
      end

      wait_drain();
      repeat (16) @(negedge clock);
      $display("%0d requests (%0d directed), %0d results, %0d of them empty",
               requests_sent, directed_items, results_seen, empties_seen);
      $display("%0d ring rebuilds, largest ring %0d people", rebuilds, max_ring);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== josephus_elimination_order_top.f =====
rtl/jeo_pkg.sv
rtl/jeo_useq.sv
rtl/jeo_datapath.sv
rtl/josephus_elimination_order_top.sv
rtl/jeo_checker.sv
sim/tb_josephus_elimination_order_top.sv
